// ===== rtl/prcr_pkg.sv =====
// Shared types and constants of the predictive region cache refresh block
`timescale 1ns / 1ps
package prcr_pkg;

  // list masks
  localparam logic [4:0] ALL_LISTS     = 5'h1C;
  localparam logic [4:0] SPATIAL_LISTS = 5'h0C;
  localparam logic [4:0] OBJECT_LIST   = 5'h10;
  localparam logic [4:0] MASK_RESET    = 5'h1C;

  // Q16.16 constants
  localparam logic [31:0] JUMP_LIMIT = 32'd327680;   // 5.0
  localparam logic [32:0] RADIUS_CAP = 33'd1638400;  // 25.0
  localparam logic [32:0] RADIUS_PAD = 33'd6554;     // 0.1
  localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;

  // reciprocal of ten, scaled by 2^RECIP_SHIFT, for x / 10 with x < 2^35
  localparam logic [35:0] RECIP_TEN   = 36'd54975581389;
  localparam int          RECIP_SHIFT = 39;

  typedef enum logic [1:0] {
    OP_REFRESH    = 2'd0,
    OP_INVALIDATE = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MS_AXIS  = 2'd0,
    MS_BOUND = 2'd1,
    MS_TEN   = 2'd2
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TEN_GO,
    ST_TEN_WAIT,
    ST_AX_GO,
    ST_AX_WAIT,
    ST_BND_GO,
    ST_BND_WAIT,
    ST_PREDICT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [30:0]        sphere_radius;
    logic               predictive;
    logic               world_valid;
  } in_t;

  typedef struct packed {
    logic [4:0]         empty_mask;
    logic [4:0]         refill_mask;
    logic signed [31:0] region_x;
    logic signed [31:0] region_y;
    logic signed [31:0] region_z;
    logic [30:0]        region_radius;
    logic               region_ready;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       mul_start;
    mul_sel_t   mul_sel;
    logic [1:0] axis;
    logic       use_last;
    logic       acc_clr;
    logic       acc_add;
    logic       cmp_save;
    logic       quo_save;
    logic       sqrt_start;
    logic       commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic world;
    logic pred;
    logic init;
    logic size_ge_r;
    logic upd_full;
    logic mul_done;
    logic sqrt_done;
  } status_t;

endpackage

// ===== rtl/prcr_mul.sv =====
// Shift-and-add unsigned multiplier, one operand bit per cycle
`timescale 1ns / 1ps
module prcr_mul #(
  parameter int W = 37
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);
  localparam int CNTW = $clog2(W + 1);
  localparam logic [CNTW-1:0] ITER = CNTW'(W);

  logic [2*W-1:0] a_r, a_nxt, prod_r, prod_nxt;
  logic [W-1:0]   b_r, b_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  // iteration step
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = {{W{1'b0}}, a};
      b_nxt    = b;
      prod_nxt = '0;
      cnt_nxt  = ITER;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) prod_nxt = prod_r + a_r;
      a_nxt   = {a_r[2*W-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign prod = prod_r;
endmodule

// ===== rtl/prcr_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle
`timescale 1ns / 1ps
module prcr_sqrt #(
  parameter int W = 76
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   x,
  output logic           done,
  output logic [W/2-1:0] root
);
  localparam int CNTW = $clog2(W / 2 + 1);
  localparam logic [CNTW-1:0] ITER = CNTW'(W / 2);

  logic [W-1:0] op_r, op_nxt, res_r, res_nxt, one_r, one_nxt, trial;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  assign trial = res_r + one_r;

  // iteration step
  always_comb begin
    op_nxt   = op_r;
    res_nxt  = res_r;
    one_nxt  = one_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      op_nxt   = x;
      res_nxt  = '0;
      one_nxt  = {2'b01, {(W-2){1'b0}}};
      cnt_nxt  = ITER;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (op_r >= trial) begin
        op_nxt  = op_r - trial;
        res_nxt = {1'b0, res_r[W-1:1]} + one_r;
      end else begin
        res_nxt = {1'b0, res_r[W-1:1]};
      end
      one_nxt = {2'b00, one_r[W-1:2]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    res_r <= res_nxt;
    one_r <= one_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign root = res_r[W/2-1:0];
endmodule

// ===== rtl/prcr_dp.sv =====
// Datapath: region state, distance products, square root and result register
`timescale 1ns / 1ps
module prcr_dp #(
  parameter int CW = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  prcr_pkg::in_t         in_data,
  input  logic                  cfg_wr_en,
  input  logic [4:0]            cfg_wr_data,
  input  prcr_pkg::cmd_t        cmd,
  output prcr_pkg::status_t     st,
  output prcr_pkg::out_t        out_data
);
  import prcr_pkg::*;

  localparam int XW = (CW > 32) ? CW : 32;      // common coordinate width
  localparam int DW = XW + 1;                   // difference width
  localparam int MW = (DW > 37) ? DW : 37;      // multiplier operand width
  localparam int PW = 2 * MW;
  localparam int SW = PW + 2;                   // sum of three squares
  localparam int RW = SW / 2;
  localparam int EW = ((CW > 37) ? CW : 37) + 1;  // width before centre saturation

  in_t                item_r;
  logic [4:0]         mask_r;
  logic signed [CW-1:0] centre_r [3];
  logic signed [CW-1:0] centre_nxt [3];
  logic signed [31:0] last_r [3];
  logic signed [31:0] last_nxt [3];
  logic signed [31:0] pnt [3];
  logic [30:0]        size_r, size_nxt;
  logic               init_r, init_nxt;
  logic [SW-1:0]      acc_r;
  logic               lt_r;
  logic [34:0]        quo_r;
  out_t               out_r;

  logic [MW-1:0]      mul_a, mul_b;
  logic               mul_done;
  logic [PW-1:0]      prod;
  logic               sqrt_done;
  logic [RW-1:0]      vel;

  logic signed [DW-1:0] p_sel, b_sel, diff;
  logic [DW-1:0]      mag;
  logic [31:0]        bound;
  logic [34:0]        r11;
  logic [4:0]         upd, empty, refill;
  logic [30:0]        plain_rad;
  logic [32:0]        pred_rad;
  logic               jump;
  op_t                op;

  // saturate to the centre width
  function automatic logic signed [CW-1:0] sat_c(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi, lo;
    hi = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    if (v > hi)      sat_c = hi[CW-1:0];
    else if (v < lo) sat_c = lo[CW-1:0];
    else             sat_c = v[CW-1:0];
  endfunction

  assign pnt[0] = item_r.point_x;
  assign pnt[1] = item_r.point_y;
  assign pnt[2] = item_r.point_z;
  assign op     = op_t'(item_r.operation);

  // axis select for the distance products
  always_comb begin
    case (cmd.axis)
      2'd1: begin
        p_sel = DW'(pnt[1]);
        b_sel = cmd.use_last ? DW'(last_r[1]) : DW'(centre_r[1]);
      end
      2'd2: begin
        p_sel = DW'(pnt[2]);
        b_sel = cmd.use_last ? DW'(last_r[2]) : DW'(centre_r[2]);
      end
      default: begin
        p_sel = DW'(pnt[0]);
        b_sel = cmd.use_last ? DW'(last_r[0]) : DW'(centre_r[0]);
      end
    endcase
  end

  assign diff  = p_sel - b_sel;
  assign mag   = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign bound = (op == OP_REFRESH) ? {1'b0, size_r - item_r.sphere_radius}
                                    : {1'b0, size_r} + {1'b0, item_r.sphere_radius};
  assign r11   = {item_r.sphere_radius, 3'b000} + {3'b000, item_r.sphere_radius, 1'b0}
               + {4'b0000, item_r.sphere_radius};

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MS_BOUND: begin
        mul_a = MW'(bound);
        mul_b = MW'(bound);
      end
      MS_TEN: begin
        mul_a = MW'(r11);
        mul_b = MW'(RECIP_TEN);
      end
      default: begin
        mul_a = MW'(mag);
        mul_b = MW'(mag);
      end
    endcase
  end

  prcr_mul #(.W(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  prcr_sqrt #(.W(SW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .x     (acc_r),
    .done  (sqrt_done),
    .root  (vel)
  );

  // update mask from the containment result
  assign upd = (mask_r & OBJECT_LIST) | (lt_r ? 5'd0 : (mask_r & SPATIAL_LISTS));

  // status to the controller
  always_comb begin
    st.op        = op;
    st.world     = item_r.world_valid;
    st.pred      = item_r.predictive;
    st.init      = init_r;
    st.size_ge_r = (size_r >= item_r.sphere_radius);
    st.upd_full  = (upd == mask_r);
    st.mul_done  = mul_done;
    st.sqrt_done = sqrt_done;
  end

  // resize candidates
  assign plain_rad = (quo_r > 35'(RADIUS_MAX)) ? RADIUS_MAX : quo_r[30:0];
  assign jump      = (vel > RW'(JUMP_LIMIT));
  always_comb begin
    logic [20:0] v5;
    logic [32:0] rad;
    v5       = {1'b0, vel[19:0]} + {vel[18:0], 2'b00};
    rad      = 33'(item_r.sphere_radius) + 33'(v5[20:1]) + RADIUS_PAD;
    pred_rad = (rad > RADIUS_CAP) ? RADIUS_CAP : rad;
  end

  // next region state at commit
  always_comb begin
    logic signed [32:0] d;
    logic signed [35:0] t, q;
    logic signed [36:0] s;
    logic resize, predict;
    empty   = 5'd0;
    refill  = 5'd0;
    size_nxt = size_r;
    init_nxt = init_r;
    resize  = 1'b0;
    predict = 1'b0;
    for (int i = 0; i < 3; i++) begin
      centre_nxt[i] = centre_r[i];
      last_nxt[i]   = last_r[i];
    end
    case (op)
      OP_REFRESH: begin
        if (!item_r.world_valid) begin
          empty = ALL_LISTS;
        end else begin
          if (upd != 5'd0) begin
            empty    = upd;
            refill   = upd;
            init_nxt = 1'b1;
            resize   = (upd == mask_r);
            predict  = item_r.predictive && init_r && !jump;
          end
          if (item_r.predictive) begin
            for (int i = 0; i < 3; i++) last_nxt[i] = pnt[i];
          end
        end
      end
      OP_INVALIDATE: begin
        if (lt_r && init_r) begin
          init_nxt = 1'b0;
          empty    = ALL_LISTS;
        end
      end
      OP_CLEAR: begin
        if (init_r) begin
          init_nxt = 1'b0;
          empty    = ALL_LISTS;
        end
      end
      default: begin
        empty = 5'd0;
      end
    endcase
    if (resize) begin
      for (int i = 0; i < 3; i++) begin
        d = 33'(pnt[i]) - 33'(last_r[i]);
        t = (36'(d) <<< 2) + 36'(d);
        // halve toward zero: add one to negatives before the arithmetic shift
        q = (t + $signed({35'd0, t[35]})) >>> 1;
        s = 37'(pnt[i]) + 37'(q);
        centre_nxt[i] = predict ? sat_c(EW'(s)) : sat_c(EW'(pnt[i]));
      end
      size_nxt = predict ? pred_rad[30:0] : plain_rad;
    end
  end

  // configuration and region state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
      size_r <= '0;
      init_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        centre_r[i] <= '0;
        last_r[i]   <= '0;
      end
    end else begin
      if (cfg_wr_en) mask_r <= cfg_wr_data;
      if (cmd.commit) begin
        size_r <= size_nxt;
        init_r <= init_nxt;
        for (int i = 0; i < 3; i++) begin
          centre_r[i] <= centre_nxt[i];
          last_r[i]   <= last_nxt[i];
        end
      end
    end
  end

  // working registers and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.capture) lt_r <= 1'b0;
    else if (cmd.cmp_save) lt_r <= (acc_r < SW'(prod));
    if (cmd.acc_clr) acc_r <= '0;
    else if (cmd.acc_add) acc_r <= acc_r + SW'(prod);
    if (cmd.quo_save) quo_r <= prod[RECIP_SHIFT +: 35];
    if (cmd.commit) begin
      out_r.empty_mask    <= empty;
      out_r.refill_mask   <= refill;
      out_r.region_x      <= 32'(centre_nxt[0]);
      out_r.region_y      <= 32'(centre_nxt[1]);
      out_r.region_z      <= 32'(centre_nxt[2]);
      out_r.region_radius <= size_nxt;
      out_r.region_ready  <= init_nxt;
    end
  end

  assign out_data = out_r;
endmodule

// ===== rtl/prcr_ctrl.sv =====
// Controller: sequences the products, square root and commit of one transaction
`timescale 1ns / 1ps
module prcr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  prcr_pkg::status_t st,
  output prcr_pkg::cmd_t    cmd
);
  import prcr_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       free;

  assign free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    phase_nxt = phase_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        axis_nxt  = 2'd0;
        phase_nxt = 1'b0;
        if (st.op == OP_REFRESH && st.world) state_nxt = ST_TEN_GO;
        else if (st.op == OP_INVALIDATE)     state_nxt = ST_AX_GO;
        else                                 state_nxt = ST_COMMIT;
      end
      ST_TEN_GO: state_nxt = ST_TEN_WAIT;
      ST_TEN_WAIT: begin
        if (st.mul_done) begin
          if (st.init && st.size_ge_r) state_nxt = ST_AX_GO;
          else                         state_nxt = ST_PREDICT;
        end
      end
      ST_AX_GO: state_nxt = ST_AX_WAIT;
      ST_AX_WAIT: begin
        if (st.mul_done) begin
          if (axis_r == 2'd2) begin
            axis_nxt  = 2'd0;
            state_nxt = phase_r ? ST_SQ_GO : ST_BND_GO;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = ST_AX_GO;
          end
        end
      end
      ST_BND_GO: state_nxt = ST_BND_WAIT;
      ST_BND_WAIT: if (st.mul_done) state_nxt = ST_PREDICT;
      ST_PREDICT: begin
        if (st.op == OP_REFRESH && st.pred && st.init && st.upd_full) begin
          phase_nxt = 1'b1;
          state_nxt = ST_AX_GO;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_SQ_GO: state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT: if (st.sqrt_done) state_nxt = ST_COMMIT;
      ST_COMMIT: if (free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd            = '0;
    cmd.mul_sel    = MS_AXIS;
    cmd.axis       = axis_r;
    cmd.use_last   = phase_r;
    in_ready       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_TEN_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_TEN;
      end
      ST_TEN_WAIT: cmd.quo_save = st.mul_done;
      ST_AX_GO: begin
        cmd.mul_start = 1'b1;
        cmd.acc_clr   = (axis_r == 2'd0);
      end
      ST_AX_WAIT: cmd.acc_add = st.mul_done;
      ST_BND_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_BOUND;
      end
      ST_BND_WAIT: cmd.cmp_save = st.mul_done;
      ST_SQ_GO: cmd.sqrt_start = 1'b1;
      ST_COMMIT: cmd.commit = free;
      default: cmd.capture = 1'b0;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= 2'd0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten while stalled");

  // an accepted transaction is decoded next
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("accepted transaction not decoded");

  // product completions arrive only while a product is awaited
  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st.mul_done |-> (state_r == ST_TEN_WAIT || state_r == ST_AX_WAIT ||
                     state_r == ST_BND_WAIT))
    else $error("unexpected product completion");

  // a new result appears only from a commit
  a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result valid without commit");

  // axis counter stays within three axes
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    axis_r != 2'd3)
    else $error("axis counter out of range");
endmodule

// ===== rtl/predictive_region_cache_refresh.sv =====
// Top level of the predictive region cache refresh block
//
// Holds one cached sphere region for a collision query. Each input
// transaction (in_valid/in_ready, payload in_data) is a refresh, an
// intersect-invalidate or a clear; each produces exactly one result
// transaction (out_valid/out_ready, payload out_data) with the list masks
// and the region after the step. cfg_wr_en/cfg_wr_data write the type mask;
// the user must write only while the block is idle; no check enforces it.
// One transaction at a time: a clear passes from accept through decode to
// commit; a refresh or invalidate runs up to eight products through one
// shift-add multiplier of MW = max(COORD_WIDTH+1, 37) bits, plus a
// bit-serial square root that yields MW+1 result bits.
// The result waits in an output register; the next transaction is accepted
// while it waits, and the block stalls only at commit until it is taken.
// Synchronous reset clears the region, the last point and the type mask
// (to barriers, instances and objects); no clearing pass is needed.
`timescale 1ns / 1ps
module predictive_region_cache_refresh #(
  parameter int COORD_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  prcr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output prcr_pkg::out_t out_data,
  input  logic           cfg_wr_en,
  input  logic [4:0]     cfg_wr_data
);
  import prcr_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer
  prcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // arithmetic and region state
  prcr_dp #(.CW(COORD_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .st          (st),
    .out_data    (out_data)
  );
endmodule
